>>> src/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes for the ordered array list: command and result
// beats, per-cell control, op codes, status codes and shift modes.
// ----------------------------------------------------------------------------
package oal_pkg;

  // default number of list entries
  localparam int CAPACITY_DEF = 64;

  // matches are scanned this many cells per cycle
  localparam int SCAN_W   = 8;
  localparam int SCAN_SEL = 3;

  // op codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_APPEND = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_PRESENT  = 3'd4;

  // cell update modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_APPEND = 2'd3;

  // command beat
  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         position;
    logic signed [31:0] value;
  } item_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_at;
    logic [6:0] count;
    logic       is_empty;
  } result_t;

  // control broadcast to every cell
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  position;
    logic [31:0] value;
    logic        capture;
  } cell_ctl_t;

endpackage

>>> src/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell
// One list entry: holds a value, takes it from a neighbor on insert or
// delete, loads the broadcast value at its own slot, and records a match.
// ----------------------------------------------------------------------------
module oal_cell
  import oal_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] fill,
  input  logic [31:0]      left,
  input  logic [31:0]      right,
  output logic [31:0]      data,
  output logic             match
);

  localparam int CW = (CNT_W > 6) ? CNT_W : 6;

  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] fill_ext;

  assign idx      = CW'(INDEX);
  assign pos      = CW'(ctl.position);
  assign fill_ext = CW'(fill);

  // entry value: shift with neighbors or load at own slot
  always_ff @(posedge clk) begin
    case (ctl.mode)
      MODE_INSERT: begin
        if (idx == pos) begin
          data <= ctl.value;
        end else if (idx > pos) begin
          data <= left;
        end
      end
      MODE_DELETE: begin
        if (idx >= pos) begin
          data <= right;
        end
      end
      MODE_APPEND: begin
        if (idx == fill_ext) begin
          data <= ctl.value;
        end
      end
      default: begin
      end
    endcase
  end

  // match flag, only for entries in use
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (data == ctl.value) && (idx < fill_ext);
    end
  end

endmodule

>>> src/oal_ctrl.sv
// ----------------------------------------------------------------------------
// oal_ctrl
// Command sequencer: checks insert, delete and append against fill, drives the
// cells, scans the match flags eight at a time and issues the result beat.
// ----------------------------------------------------------------------------
module oal_ctrl
  import oal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  item_t               command,
  input  logic [CAPACITY-1:0] hits,
  output logic                busy,
  output cell_ctl_t           ctl,
  output logic [CNT_W-1:0]    fill,
  output logic                done,
  output result_t             result
);

  localparam int CW    = (CNT_W > 6) ? CNT_W : 6;
  localparam int NGRP  = (CAPACITY + SCAN_W - 1) / SCAN_W;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int HW    = GRP_W + SCAN_SEL;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  item_t                  item;
  logic [GRP_W-1:0]       grp;
  logic [GRP_W-1:0]       grp_next;
  logic [CNT_W-1:0]       fill_next;
  logic                   finish;
  result_t                result_next;
  logic [NGRP*SCAN_W-1:0] match_pad;
  logic [SCAN_W-1:0]      grp_bits;
  logic [SCAN_SEL-1:0]    first;
  logic [HW-1:0]          hit_idx;
  logic                   full;
  logic [CW-1:0]          pos_ext;
  logic [CW-1:0]          fill_ext;

  assign busy     = (state != S_IDLE);
  assign full     = (fill == CNT_W'(CAPACITY));
  assign pos_ext  = CW'(item.position);
  assign fill_ext = CW'(fill);

  // pad match flags to whole scan groups
  always_comb begin
    match_pad                 = '0;
    match_pad[CAPACITY-1:0]   = hits;
  end

  // first set flag in the current group
  always_comb begin
    grp_bits = match_pad[grp*SCAN_W +: SCAN_W];
    first    = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        first = SCAN_SEL'(i);
      end
    end
    hit_idx = {grp, first};
  end

  // sequencer and op checks
  always_comb begin
    state_next           = state;
    grp_next             = grp;
    fill_next            = fill;
    finish               = 1'b0;
    ctl.mode             = MODE_HOLD;
    ctl.position         = item.position;
    ctl.value            = item.value;
    ctl.capture          = 1'b0;
    result_next.status   = ST_OK;
    result_next.found_at = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        grp_next = '0;
        unique case (item.op) inside
          OP_INSERT: begin
            finish = 1'b1;
            if (full) begin
              result_next.status = ST_FULL;
            end else if (pos_ext > fill_ext) begin
              result_next.status = ST_BADPOS;
            end else begin
              ctl.mode  = MODE_INSERT;
              fill_next = fill + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            finish = 1'b1;
            if (pos_ext >= fill_ext) begin
              result_next.status = ST_BADPOS;
            end else begin
              ctl.mode  = MODE_DELETE;
              fill_next = fill - CNT_W'(1);
            end
          end
          OP_CLEAR: begin
            finish    = 1'b1;
            fill_next = '0;
          end
          OP_FIND, OP_APPEND: begin
            ctl.capture = 1'b1;
            state_next  = S_SCAN;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (|grp_bits) begin
          finish               = 1'b1;
          result_next.found_at = 6'(hit_idx);
          result_next.status   = (item.op == OP_FIND) ? ST_OK : ST_PRESENT;
        end else if (grp == GRP_W'(NGRP - 1)) begin
          finish = 1'b1;
          if (item.op == OP_FIND) begin
            result_next.status = ST_NOTFOUND;
          end else if (full) begin
            result_next.status = ST_FULL;
          end else begin
            ctl.mode             = MODE_APPEND;
            result_next.found_at = 6'(fill);
            fill_next            = fill + CNT_W'(1);
          end
        end else begin
          grp_next = grp + GRP_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
    result_next.count    = 7'(fill_next);
    result_next.is_empty = (fill_next == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
      grp   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= finish;
      grp   <= grp_next;
    end
  end

  // command and result beat registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= command;
    end
    if (finish) begin
      result <= result_next;
    end
  end

endmodule

>>> src/ordered_array_list.sv
// ----------------------------------------------------------------------------
// ordered_array_list
// Fixed-capacity list of signed 32-bit values held in a row of cells, with
// insert, delete, find, clear and append-if-absent.
// ----------------------------------------------------------------------------
// Insert, delete, clear: the result beat is issued from the execute state,
//   and the next command is taken once busy falls.
// Find, append-if-absent: the result time is set by the scan of the cell
//   match flags, eight cells per cycle.
// Reset clears the sequencer state and fill count; entry storage is not cleared.
// Result beats cannot be stalled; busy is high while a command is in work.
// ----------------------------------------------------------------------------
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   command,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t           ctl;
  logic [CNT_W-1:0]    fill;
  logic [31:0]         data [CAPACITY];
  logic [CAPACITY-1:0] hits;

  // sequencer
  oal_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .hits    (hits),
    .busy    (busy),
    .ctl     (ctl),
    .fill    (fill),
    .done    (done),
    .result  (result)
  );

  // row of cells linked to neighbors; end cells use ctl.value or own data
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left;
    logic [31:0] right;

    if (i == 0) begin : g_first
      assign left = ctl.value;
    end else begin : g_mid_l
      assign left = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = data[i];
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    oal_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .fill  (fill),
      .left  (left),
      .right (right),
      .data  (data[i]),
      .match (hits[i])
    );
  end

endmodule

>>> tb/tb_ordered_array_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list
// Self-checking bench for the ordered array list. A shadow copy of the list
// predicts every result beat. Directed beats cover empty, bad position,
// present, not found and unused op cases. Random phases then grow the list
// to full, shrink it and mix all ops, with bursty command traffic.
// ----------------------------------------------------------------------------
module tb_ordered_array_list;
  import oal_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef enum {PHASE_GROW, PHASE_SHRINK, PHASE_MIX} phase_t;

  // shadow list and expected result beats
  class list_tracker;
    logic [31:0] cells [CAP];
    int          fill;
    result_t     expected_results [$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // first index holding v, -1 if absent
    function int locate(logic [31:0] v);
      for (int k = 0; k < fill; k++)
        if (cells[k] == v)
          return k;
      return -1;
    endfunction

    // apply one command to the shadow list and form its result
    function result_t apply_command(item_t c);
      result_t r;
      int      hit;
      int      k;
      int      pos;
      r.status   = ST_OK;
      r.found_at = '0;
      pos        = int'(c.position);
      case (c.op)
        OP_INSERT: begin
          if (fill >= CAP) begin
            r.status = ST_FULL;
          end else if (pos > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (k = fill; k > pos; k--)
              cells[k] = cells[k - 1];
            cells[pos] = c.value;
            fill++;
          end
        end
        OP_DELETE: begin
          if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (k = pos; k + 1 < fill; k++)
              cells[k] = cells[k + 1];
            fill--;
          end
        end
        OP_FIND: begin
          hit = locate(c.value);
          if (hit < 0)
            r.status = ST_NOTFOUND;
          else
            r.found_at = hit[5:0];
        end
        OP_CLEAR: begin
          fill = 0;
        end
        OP_APPEND: begin
          hit = locate(c.value);
          if (hit >= 0) begin
            r.status   = ST_PRESENT;
            r.found_at = hit[5:0];
          end else if (fill >= CAP) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = c.value;
            r.found_at  = fill[5:0];
            fill++;
          end
        end
        default: ;
      endcase
      r.count    = fill[6:0];
      r.is_empty = (fill == 0);
      return r;
    endfunction

    function void log_command(item_t c);
      expected_results.push_back(apply_command(c));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat: status %0d found_at %0d count %0d empty %0d",
                   got.status, got.found_at, got.count, got.is_empty);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.found_at !== want.found_at ||
          got.count !== want.count || got.is_empty !== want.is_empty) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected status %0d found_at %0d count %0d empty %0d, %s",
                   want.status, want.found_at, want.count, want.is_empty,
                   $sformatf("got status %0d found_at %0d count %0d empty %0d",
                             got.status, got.found_at, got.count, got.is_empty));
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   command = '0;
  logic    busy;
  logic    done;
  result_t result;

  list_tracker tracker = new();
  int          n_accepted = 0;
  int          idle_cycles = 0;

  ordered_array_list #(.CAPACITY(CAP)) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always #1 clk = ~clk;

  // observe result and command beats, watchdog on stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        tracker.check_result(result);
      if (start && !busy) begin
        tracker.log_command(command);
        n_accepted++;
      end
      if (done || (start && !busy))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL ordered_array_list");
        $finish;
      end
    end
  end

  // present one command beat and hold it until accepted
  task automatic send_command(input logic [2:0] op, input logic [5:0] pos,
                              input logic [31:0] val);
    int seen;
    seen = n_accepted;
    start            <= 1'b1;
    command.op       <= op;
    command.position <= pos;
    command.value    <= val;
    wait (n_accepted != seen);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every expected result beat has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] pool [8];
    int          r;
    pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h5, 32'hA5A5_A5A5, 32'h2};
    r = $urandom_range(0, 99);
    if (r < 40 && tracker.fill > 0)
      return tracker.cells[$urandom_range(0, tracker.fill - 1)];
    else if (r < 70)
      return pool[$urandom_range(0, 7)];
    else
      return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PHASE_GROW: begin
        if (r < 50) return OP_INSERT;
        if (r < 85) return OP_APPEND;
        if (r < 92) return OP_FIND;
        if (r < 97) return OP_DELETE;
      end
      PHASE_SHRINK: begin
        if (r < 60) return OP_DELETE;
        if (r < 75) return OP_FIND;
        if (r < 85) return OP_INSERT;
        if (r < 97) return OP_APPEND;
      end
      default: begin
        if (r < 25) return OP_INSERT;
        if (r < 45) return OP_DELETE;
        if (r < 67) return OP_FIND;
        if (r < 95) return OP_APPEND;
        if (r < 97) return OP_CLEAR;
      end
    endcase
    return 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [5:0] pick_position(logic [2:0] op);
    int r;
    r = $urandom_range(0, 99);
    if (op == OP_INSERT && r < 85)
      return 6'((tracker.fill > 63) ? $urandom_range(0, 63)
                                    : $urandom_range(0, tracker.fill));
    if (op == OP_DELETE && r < 85 && tracker.fill > 0)
      return 6'($urandom_range(0, tracker.fill - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    phase_t      ph;
    logic [2:0]  op;
    int          counted;
    int          round_left;
    int          burst_left;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, bounds, duplicates, unused ops, clear
    send_command(OP_FIND,   6'd0,  32'h5);
    send_command(OP_DELETE, 6'd0,  32'h0);
    send_command(OP_INSERT, 6'd1,  32'h7);
    send_command(OP_INSERT, 6'd0,  32'h8000_0000);
    send_command(OP_APPEND, 6'd0,  32'h7FFF_FFFF);
    send_command(OP_APPEND, 6'd63, 32'h7FFF_FFFF);
    send_command(OP_INSERT, 6'd2,  32'hFFFF_FFFF);
    send_command(OP_INSERT, 6'd4,  32'h3);
    send_command(OP_FIND,   6'd0,  32'hFFFF_FFFF);
    send_command(OP_FIND,   6'd0,  32'h0);
    send_command(OP_INSERT, 6'd63, 32'h0);
    send_command(3'd5,      6'd0,  32'h0);
    send_command(3'd6,      6'd21, 32'h1234_5678);
    send_command(3'd7,      6'd63, 32'hFFFF_FFFF);
    send_command(OP_DELETE, 6'd3,  32'h0);
    send_command(OP_DELETE, 6'd1,  32'h0);
    send_command(OP_DELETE, 6'd0,  32'h0);
    send_command(OP_FIND,   6'd0,  32'h8000_0000);
    send_command(OP_CLEAR,  6'd63, 32'hFFFF_FFFF);
    send_command(OP_FIND,   6'd0,  32'hFFFF_FFFF);
    send_command(OP_DELETE, 6'd0,  32'h0);
    send_command(OP_APPEND, 6'd0,  32'h0);
    drain();

    // random phases with bursty command traffic
    counted    = 0;
    burst_left = $urandom_range(1, 40);
    while (counted < RANDOM_ITEMS) begin
      ph = phase_t'($urandom_range(0, 2));
      round_left = $urandom_range(80, 160);
      if ($urandom_range(0, 2) == 0)
        drain();
      while (round_left > 0 && counted < RANDOM_ITEMS) begin
        op = pick_op(ph);
        send_command(op, pick_position(op), pick_value());
        round_left--;
        if (op <= OP_APPEND)
          counted++;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 9) == 0)
            pause($urandom_range(15, 25));
          else
            pause($urandom_range(1, 8));
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 40);
        end
      end
    end

    // let the last beats come back
    drain();
    repeat (12) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASS ordered_array_list");
    else
      $display("FAIL ordered_array_list");
    $finish;
  end

endmodule
